FILE: src/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, defaults and register indexes of the ray-triangle engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

   localparam int COORD_W       = 32;
   localparam int DIFF_W        = 33;
   localparam int PROD_W        = 66;
   localparam int CROSS_W       = 67;
   localparam int LO_W          = 33;
   localparam int PART_W        = 67;
   localparam int NUM_W         = 104;
   localparam int TOL_W         = 16;
   localparam int TCH_W         = 26;
   localparam int TCH_N         = 4;
   localparam int TD_W          = NUM_W + TOL_W;
   localparam int DIST_W        = 31;
   localparam int BARY_W        = 18;
   localparam int DIV_STAGES    = 31;
   localparam int PRE_STAGES    = 10;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ADDR_W        = 5;
   localparam int DATA_W        = 32;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5,
      REG_TOL      = 3'd6
   } reg_index_type;

endpackage

`default_nettype wire

FILE: src/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider; each of the last QB stages gives one quotient
// bit; saturation flags mark numerators below zero or at or above den * 2^QB.
// ----------------------------------------------------------------------------
`default_nettype none

module rti_div #(
   parameter int RW     = 137,
   parameter int NW     = 104,
   parameter int QB     = 31,
   parameter int STAGES = 31
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [RW-1:0] num,
   input  wire logic [NW-1:0]        den,
   output logic [QB-1:0]             quo
);

   logic [RW-1:0] rem_ff [STAGES];
   logic [NW-1:0] den_ff [STAGES];
   logic [QB-1:0] q_ff   [STAGES];
   logic          hi_ff  [STAGES];
   logic          lo_ff  [STAGES];

   logic [RW-1:0] rem_pv [STAGES];
   logic [NW-1:0] den_pv [STAGES];
   logic [QB-1:0] q_pv   [STAGES];
   logic          hi_pv  [STAGES];
   logic          lo_pv  [STAGES];

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         localparam int K = STAGES - 1 - s;
         logic [RW-1:0] rem_in;
         logic [QB-1:0] q_in;

         if (s == 0) begin : g_first
            always_comb begin
               rem_pv[s] = RW'(num);
               den_pv[s] = den;
               q_pv[s]   = '0;
               lo_pv[s]  = num[RW-1];
               hi_pv[s]  = !num[RW-1] && (RW'(num) >= (RW'(den) << QB));
            end
         end else begin : g_next
            always_comb begin
               rem_pv[s] = rem_ff[s-1];
               den_pv[s] = den_ff[s-1];
               q_pv[s]   = q_ff[s-1];
               lo_pv[s]  = lo_ff[s-1];
               hi_pv[s]  = hi_ff[s-1];
            end
         end

         if (K < QB) begin : g_bit
            logic [RW-1:0] dsh;
            always_comb begin
               dsh    = RW'(den_pv[s]) << K;
               rem_in = rem_pv[s];
               q_in   = q_pv[s];
               if (rem_pv[s] >= dsh) begin
                  rem_in  = rem_pv[s] - dsh;
                  q_in[K] = 1'b1;
               end
            end
         end else begin : g_pass
            always_comb begin
               rem_in = rem_pv[s];
               q_in   = q_pv[s];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_pv[s];
               q_ff[s]   <= q_in;
               hi_ff[s]  <= hi_pv[s];
               lo_ff[s]  <= lo_pv[s];
            end
         end
      end
   endgenerate

   always_comb begin
      priority if (hi_ff[STAGES-1]) begin
         quo = '1;
      end else if (lo_ff[STAGES-1]) begin
         quo = '0;
      end else begin
         quo = q_ff[STAGES-1];
      end
   end

endmodule

`default_nettype wire

FILE: src/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray-triangle test against a ray held in CSRs. One triangle
// item may enter every cycle; each item returns one result item through
// 10 arithmetic stages, 31 divider stages set by the 31-bit distance
// quotient and one output register. All tests are exact; t, u and v are
// floored and saturated. A result waiting on the output blocks new items
// only once another item has reached the last divider stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_a_x,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_a_y,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_a_z,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_b_x,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_b_y,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_b_z,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_c_x,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_c_y,
   input  wire logic signed [rti_pkg::COORD_W-1:0]    req_vertex_c_z,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic [rti_pkg::DIST_W-1:0]                 rsp_distance,
   output logic signed [rti_pkg::BARY_W-1:0]          rsp_bary_u,
   output logic signed [rti_pkg::BARY_W-1:0]          rsp_bary_v,

   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rti_pkg::ADDR_W-1:0]            csr_paddr,
   input  wire logic [rti_pkg::DATA_W-1:0]            csr_pwdata,
   output logic [rti_pkg::DATA_W-1:0]                 csr_prdata,
   output logic                                       csr_pready
);

   localparam int DW   = rti_pkg::DIFF_W;
   localparam int NW   = rti_pkg::NUM_W;
   localparam int PRE  = rti_pkg::PRE_STAGES;
   localparam int DS   = rti_pkg::DIV_STAGES;
   localparam int SHW  = (FRAC_BITS > rti_pkg::DIST_W) ? FRAC_BITS : rti_pkg::DIST_W;
   localparam int RW   = NW + SHW + 2;

   typedef logic signed [RW-1:0] wide_type;

   // configuration registers
   logic signed [rti_pkg::COORD_W-1:0] origin_ff [3];
   logic signed [rti_pkg::COORD_W-1:0] dir_ff    [3];
   logic [rti_pkg::TOL_W-1:0]          tol_ff;
   logic                               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            origin_ff[i] <= '0;
            dir_ff[i]    <= '0;
         end
         tol_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            rti_pkg::REG_ORIGIN_X: origin_ff[0] <= csr_pwdata;
            rti_pkg::REG_ORIGIN_Y: origin_ff[1] <= csr_pwdata;
            rti_pkg::REG_ORIGIN_Z: origin_ff[2] <= csr_pwdata;
            rti_pkg::REG_DIR_X:    dir_ff[0]    <= csr_pwdata;
            rti_pkg::REG_DIR_Y:    dir_ff[1]    <= csr_pwdata;
            rti_pkg::REG_DIR_Z:    dir_ff[2]    <= csr_pwdata;
            rti_pkg::REG_TOL:      tol_ff       <= csr_pwdata[rti_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         rti_pkg::REG_ORIGIN_X: csr_prdata = origin_ff[0];
         rti_pkg::REG_ORIGIN_Y: csr_prdata = origin_ff[1];
         rti_pkg::REG_ORIGIN_Z: csr_prdata = origin_ff[2];
         rti_pkg::REG_DIR_X:    csr_prdata = dir_ff[0];
         rti_pkg::REG_DIR_Y:    csr_prdata = dir_ff[1];
         rti_pkg::REG_DIR_Z:    csr_prdata = dir_ff[2];
         rti_pkg::REG_TOL:      csr_prdata = rti_pkg::DATA_W'(tol_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // flow control
   logic [PRE-1:0] v_ff;
   logic [DS-1:0]  dv_ff;
   logic [DS-1:0]  dmiss_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           last_valid;
   logic           en;
   logic           accept;

   assign last_valid = dv_ff[DS-1];
   assign en         = !last_valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !en;
   assign accept     = req_valid && en;

   // stage 1: edges and origin offset
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] t_ff  [3];
   logic signed [rti_pkg::COORD_W-1:0] va [3];
   logic signed [rti_pkg::COORD_W-1:0] vb [3];
   logic signed [rti_pkg::COORD_W-1:0] vc [3];

   always_comb begin
      va[0] = req_vertex_a_x; va[1] = req_vertex_a_y; va[2] = req_vertex_a_z;
      vb[0] = req_vertex_b_x; vb[1] = req_vertex_b_y; vb[2] = req_vertex_b_z;
      vc[0] = req_vertex_c_x; vc[1] = req_vertex_c_y; vc[2] = req_vertex_c_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= DW'(vb[i]) - DW'(va[i]);
            e2_ff[i] <= DW'(vc[i]) - DW'(va[i]);
            t_ff[i]  <= DW'(origin_ff[i]) - DW'(va[i]);
         end
      end
   end

   // stage 2: cross product terms for e2 x e1, e2 x t, t x e1
   logic signed [DW-1:0] xa [3][3];
   logic signed [DW-1:0] xb [3][3];
   logic signed [rti_pkg::PROD_W-1:0] pa_ff [3][3];
   logic signed [rti_pkg::PROD_W-1:0] pb_ff [3][3];
   logic signed [DW-1:0] e2_2_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xa[0][i] = e2_ff[i]; xb[0][i] = e1_ff[i];
         xa[1][i] = e2_ff[i]; xb[1][i] = t_ff[i];
         xa[2][i] = t_ff[i];  xb[2][i] = e1_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
               pa_ff[c][i] <= xa[c][(i+1)%3] * xb[c][(i+2)%3];
               pb_ff[c][i] <= xa[c][(i+2)%3] * xb[c][(i+1)%3];
            end
         end
         e2_2_ff <= e2_ff;
      end
   end

   // stage 3: cross products
   logic signed [rti_pkg::CROSS_W-1:0] cr_ff [3][3];
   logic signed [DW-1:0] e2_3_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
               cr_ff[c][i] <= rti_pkg::CROSS_W'(pa_ff[c][i])
                            - rti_pkg::CROSS_W'(pb_ff[c][i]);
            end
         end
         e2_3_ff <= e2_2_ff;
      end
   end

   // stage 4: split dot products det, nu, nv, nt
   logic signed [rti_pkg::CROSS_W-1:0] dv_a [4][3];
   logic signed [DW-1:0]               dv_b [4][3];
   logic signed [rti_pkg::PART_W-1:0]  plo_ff [4][3];
   logic signed [rti_pkg::PART_W-1:0]  phi_ff [4][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_a[0][i] = cr_ff[0][i]; dv_b[0][i] = DW'(dir_ff[i]);
         dv_a[1][i] = cr_ff[1][i]; dv_b[1][i] = DW'(dir_ff[i]);
         dv_a[2][i] = cr_ff[2][i]; dv_b[2][i] = DW'(dir_ff[i]);
         dv_a[3][i] = cr_ff[2][i]; dv_b[3][i] = e2_3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 4; n++) begin
            for (int i = 0; i < 3; i++) begin
               plo_ff[n][i] <= $signed({1'b0, dv_a[n][i][rti_pkg::LO_W-1:0]}) * dv_b[n][i];
               phi_ff[n][i] <= $signed(dv_a[n][i][rti_pkg::CROSS_W-1:rti_pkg::LO_W])
                             * dv_b[n][i];
            end
         end
      end
   end

   // stage 5: join partial products
   logic signed [NW-1:0] pr_ff [4][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 4; n++) begin
            for (int i = 0; i < 3; i++) begin
               pr_ff[n][i] <= (NW'(phi_ff[n][i]) <<< rti_pkg::LO_W) + NW'(plo_ff[n][i]);
            end
         end
      end
   end

   // stage 6: sums
   logic signed [NW-1:0] num_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 4; n++) begin
            num_ff[n] <= pr_ff[n][0] + pr_ff[n][1] + pr_ff[n][2];
         end
      end
   end

   // stage 7: make det positive
   logic signed [NW-1:0] nd_ff [4];
   logic                 zero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 4; n++) begin
            nd_ff[n] <= num_ff[0][NW-1] ? -num_ff[n] : num_ff[n];
         end
         zero_ff <= (num_ff[0] == '0);
      end
   end

   // stage 8: tolerance times det, partial products
   logic [rti_pkg::TOL_W+rti_pkg::TCH_W-1:0] tp_ff [rti_pkg::TCH_N];
   logic signed [NW-1:0] nd8_ff [4];
   logic                 zero8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < rti_pkg::TCH_N; k++) begin
            tp_ff[k] <= tol_ff * nd_ff[0][k*rti_pkg::TCH_W +: rti_pkg::TCH_W];
         end
         nd8_ff   <= nd_ff;
         zero8_ff <= zero_ff;
      end
   end

   // stage 9: tolerance times det
   logic [rti_pkg::TD_W-1:0] td_in;
   logic [rti_pkg::TD_W-1:0] td_ff;
   logic signed [NW-1:0]     nd9_ff [4];
   logic                     zero9_ff;

   always_comb begin
      td_in = '0;
      for (int k = 0; k < rti_pkg::TCH_N; k++) begin
         td_in = td_in + (rti_pkg::TD_W'(tp_ff[k]) << (k * rti_pkg::TCH_W));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         td_ff    <= td_in;
         nd9_ff   <= nd8_ff;
         zero9_ff <= zero8_ff;
      end
   end

   // stage 10: border tests and divider numerators
   wide_type det_s, nu_s, nv_s, td_w;
   logic     miss_in;
   wide_type r_ff [3];
   logic [NW-1:0] den_ff;
   logic     miss_ff;

   always_comb begin
      det_s   = wide_type'(nd9_ff[0]) <<< FRAC_BITS;
      nu_s    = wide_type'(nd9_ff[1]) <<< FRAC_BITS;
      nv_s    = wide_type'(nd9_ff[2]) <<< FRAC_BITS;
      td_w    = wide_type'({1'b0, td_ff});
      miss_in = zero9_ff
             || ((nu_s + td_w) < 0)
             || ((det_s + td_w - nu_s) < 0)
             || ((nv_s + td_w) < 0)
             || ((det_s + td_w - nu_s - nv_s) < 0)
             || (nd9_ff[3] <= 0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= wide_type'(nd9_ff[3]) <<< FRAC_BITS;
         r_ff[1] <= nu_s + (wide_type'(nd9_ff[0]) <<< (rti_pkg::BARY_W - 1));
         r_ff[2] <= nv_s + (wide_type'(nd9_ff[0]) <<< (rti_pkg::BARY_W - 1));
         den_ff  <= nd9_ff[0];
         miss_ff <= miss_in;
      end
   end

   // dividers
   logic [rti_pkg::DIST_W-1:0] q_t;
   logic [rti_pkg::BARY_W-1:0] q_u;
   logic [rti_pkg::BARY_W-1:0] q_v;

   rti_div #(.RW(RW), .NW(NW), .QB(rti_pkg::DIST_W), .STAGES(DS)) u_div_t (
      .clock (clock), .en (en), .num (r_ff[0]), .den (den_ff), .quo (q_t)
   );

   rti_div #(.RW(RW), .NW(NW), .QB(rti_pkg::BARY_W), .STAGES(DS)) u_div_u (
      .clock (clock), .en (en), .num (r_ff[1]), .den (den_ff), .quo (q_u)
   );

   rti_div #(.RW(RW), .NW(NW), .QB(rti_pkg::BARY_W), .STAGES(DS)) u_div_v (
      .clock (clock), .en (en), .num (r_ff[2]), .den (den_ff), .quo (q_v)
   );

   // valid and miss lines
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         dv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            v_ff  <= {v_ff[PRE-2:0], accept};
            dv_ff <= {dv_ff[DS-2:0], v_ff[PRE-1]};
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dmiss_ff <= {dmiss_ff[DS-2:0], miss_ff};
      end
   end

   always_comb begin
      priority if (last_valid && en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // output register
   logic                               hit_ff;
   logic [rti_pkg::DIST_W-1:0]         dist_ff;
   logic signed [rti_pkg::BARY_W-1:0]  u_ff;
   logic signed [rti_pkg::BARY_W-1:0]  v_out_ff;
   logic                               miss_last;

   assign miss_last = dmiss_ff[DS-1];

   always_ff @(posedge clock) begin
      if (last_valid && en) begin
         hit_ff   <= !miss_last;
         dist_ff  <= miss_last ? '0 : q_t;
         u_ff     <= miss_last ? '0 : {~q_u[rti_pkg::BARY_W-1], q_u[rti_pkg::BARY_W-2:0]};
         v_out_ff <= miss_last ? '0 : {~q_v[rti_pkg::BARY_W-1], q_v[rti_pkg::BARY_W-2:0]};
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_distance = dist_ff;
   assign rsp_bary_u   = u_ff;
   assign rsp_bary_v   = v_out_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_distance == '0 && rsp_bary_u == '0
                                   && rsp_bary_v == '0))
      else $error("miss item carries nonzero fields");

   a_free_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (last_valid && rsp_valid && rsp_stall))
      else $error("input stalled while pipeline can advance");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

`default_nettype wire
